// ===== hw/rtl/led_flash_sequence_controller_unit_macros.svh =====
// assertion macros shared by the checker
`ifndef LED_FLASH_SEQUENCE_CONTROLLER_UNIT_MACROS_SVH
`define LED_FLASH_SEQUENCE_CONTROLLER_UNIT_MACROS_SVH

// checked on every rising edge outside reset
`define LFSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every rising edge, reset included
`define LFSC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hw/rtl/lfsc_pkg.sv =====
package lfsc_pkg;

  localparam int unsigned NUM_PATTERNS = 4;
  localparam int unsigned NUM_STEPS    = 8;
  localparam int unsigned DUR_W        = 8;
  localparam int unsigned SEL_W        = 2;
  localparam int unsigned POS_W        = 3;
  localparam int unsigned CNT_W        = 4;
  localparam int unsigned PCOUNT_W     = 3;
  localparam int unsigned SCOUNT_W     = 16;
  localparam int unsigned STIME_W      = 64;
  localparam int unsigned CLICK_W      = 3;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 64;
  localparam int unsigned IN_TDATA_W   = 8;
  localparam int unsigned OUT_TDATA_W  = 8;

  // button click codes
  localparam logic [CLICK_W-1:0] CLICK_NONE   = 3'd0;
  localparam logic [CLICK_W-1:0] CLICK_SINGLE = 3'd1;
  localparam logic [CLICK_W-1:0] CLICK_DOUBLE = 3'd2;
  localparam logic [CLICK_W-1:0] CLICK_TRIPLE = 3'd3;
  localparam logic [CLICK_W-1:0] CLICK_LONG   = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNTS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIMES_0  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIMES_1  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIMES_2  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIMES_3  = 3'd5;

  localparam logic [PCOUNT_W-1:0] PATTERN_COUNT_RST = 3'd1;
  localparam logic [SCOUNT_W-1:0] STEP_COUNTS_RST   = 16'h1111;

endpackage

// ===== hw/rtl/led_flash_sequence_controller_unit.sv =====
// LED flash sequence controller.
// Slave stream (s_axis_*) takes one event item per handshake: a tick flag and
// a button click code. Master stream (m_axis_*) returns exactly one status item
// per event: selected pattern, its current step, pause, speed and direction,
// all as they stand after that event.
// Configuration is written through cfg_valid_i/cfg_index_i/cfg_data_i; the user
// must write it only while no event is in flight, which the block does not
// enforce. cfg_ready_o is always high. Index 0 pattern count, 1 step counts,
// 2..5 step times of patterns 0..3; other indexes are ignored.
// An accepted event sits in the input register and moves through one update
// stage into the result register, from which its status item is offered on
// the master side. Throughput is one event per cycle while the receiver keeps
// up, set by the update of the pattern state between those two registers.
// When the receiver stalls, the result register holds its item and the input
// register still takes one more event; s_axis_tready drops only when both
// are full.
// Reset clears all pattern state (pattern 0 selected, running, slow, forward,
// step 0, timers zero) and loads the register defaults; no item is pending.
module led_flash_sequence_controller_unit #(
  parameter int unsigned TIME_BITS = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [0] tick, [3:1] click, [7:4] zero
  input  logic [lfsc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [1:0] pattern_index, [4:2] step_index, [5] is_paused, [6] is_fast,
  // [7] is_reverse
  output logic [lfsc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [lfsc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [lfsc_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned NP = lfsc_pkg::NUM_PATTERNS;
  localparam int unsigned CW = (TIME_BITS > lfsc_pkg::DUR_W) ? TIME_BITS : lfsc_pkg::DUR_W;
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  // configuration registers
  logic [lfsc_pkg::PCOUNT_W-1:0] pcount_q;
  logic [lfsc_pkg::SCOUNT_W-1:0] scount_q;
  logic [lfsc_pkg::STIME_W-1:0]  stime_q [NP];

  // pattern state
  logic [TIME_BITS-1:0]          el_q   [NP];
  logic [TIME_BITS-1:0]          el_d   [NP];
  logic                          fast_q [NP];
  logic                          fast_d [NP];
  logic                          back_q [NP];
  logic                          back_d [NP];
  logic [lfsc_pkg::POS_W-1:0]    pos_q  [NP];
  logic [lfsc_pkg::POS_W-1:0]    pos_d  [NP];
  logic [lfsc_pkg::SEL_W-1:0]    sel_q, sel_d;
  logic                          halt_q, halt_d;

  // input and result registers
  logic                          in_valid_q;
  logic                          in_tick_q;
  logic [lfsc_pkg::CLICK_W-1:0]  in_click_q;
  logic                          out_valid_q;
  logic [lfsc_pkg::OUT_TDATA_W-1:0] out_data_q, out_data_d;
  logic                          move;

  assign move          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || move;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcount_q <= lfsc_pkg::PATTERN_COUNT_RST;
      scount_q <= lfsc_pkg::STEP_COUNTS_RST;
      for (int i = 0; i < NP; i++) begin
        stime_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        lfsc_pkg::REG_PATTERN_COUNT: pcount_q   <= cfg_data_i[lfsc_pkg::PCOUNT_W-1:0];
        lfsc_pkg::REG_STEP_COUNTS:   scount_q   <= cfg_data_i[lfsc_pkg::SCOUNT_W-1:0];
        lfsc_pkg::REG_STEP_TIMES_0:  stime_q[0] <= cfg_data_i;
        lfsc_pkg::REG_STEP_TIMES_1:  stime_q[1] <= cfg_data_i;
        lfsc_pkg::REG_STEP_TIMES_2:  stime_q[2] <= cfg_data_i;
        lfsc_pkg::REG_STEP_TIMES_3:  stime_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [lfsc_pkg::SEL_W-1:0]    p;
    logic [lfsc_pkg::SEL_W-1:0]    q;
    logic [lfsc_pkg::PCOUNT_W-1:0] n_pat;
    logic [lfsc_pkg::CNT_W-1:0]    n_st;
    logic [lfsc_pkg::POS_W-1:0]    pos;
    logic [lfsc_pkg::DUR_W-1:0]    limit;

    el_d   = el_q;
    fast_d = fast_q;
    back_d = back_q;
    pos_d  = pos_q;
    sel_d  = sel_q;
    halt_d = halt_q;
    p      = sel_q;
    q      = sel_q;
    pos    = '0;
    limit  = '0;

    // patterns in use, clamped to 1..NUM_PATTERNS
    n_pat = pcount_q;
    if (n_pat == '0) begin
      n_pat = lfsc_pkg::PCOUNT_W'(1);
    end else if (n_pat > lfsc_pkg::PCOUNT_W'(NP)) begin
      n_pat = lfsc_pkg::PCOUNT_W'(NP);
    end
    n_st = '0;

    if (move) begin
      if (in_tick_q && !halt_q && (el_q[p] != TIME_MAX)) begin
        el_d[p] = el_q[p] + TIME_BITS'(1);
      end

      if (in_click_q == lfsc_pkg::CLICK_LONG) begin
        halt_d = !halt_q;
      end else if ((in_click_q <= lfsc_pkg::CLICK_TRIPLE) && !halt_q) begin
        unique case (in_click_q)
          lfsc_pkg::CLICK_SINGLE: begin
            if ({1'b0, sel_q} >= (n_pat - lfsc_pkg::PCOUNT_W'(1))) begin
              sel_d = '0;
            end else begin
              sel_d = sel_q + lfsc_pkg::SEL_W'(1);
            end
          end
          lfsc_pkg::CLICK_DOUBLE: fast_d[p] = !fast_q[p];
          lfsc_pkg::CLICK_TRIPLE: back_d[p] = !back_q[p];
          default: ;
        endcase

        // step check on the newly selected pattern
        q    = sel_d;
        pos  = pos_d[q];
        n_st = scount_q[lfsc_pkg::CNT_W*q +: lfsc_pkg::CNT_W];
        if (n_st == '0) begin
          n_st = lfsc_pkg::CNT_W'(1);
        end else if (n_st > lfsc_pkg::CNT_W'(lfsc_pkg::NUM_STEPS)) begin
          n_st = lfsc_pkg::CNT_W'(lfsc_pkg::NUM_STEPS);
        end
        limit = stime_q[q][lfsc_pkg::DUR_W*pos +: lfsc_pkg::DUR_W];
        if (fast_d[q]) begin
          limit = limit >> 1;
        end
        if (CW'(el_d[q]) >= CW'(limit)) begin
          el_d[q] = '0;
          if (back_d[q]) begin
            if ((pos == '0) || ({1'b0, pos} >= n_st)) begin
              pos_d[q] = lfsc_pkg::POS_W'(n_st - lfsc_pkg::CNT_W'(1));
            end else begin
              pos_d[q] = pos - lfsc_pkg::POS_W'(1);
            end
          end else begin
            if ({1'b0, pos} >= (n_st - lfsc_pkg::CNT_W'(1))) begin
              pos_d[q] = '0;
            end else begin
              pos_d[q] = pos + lfsc_pkg::POS_W'(1);
            end
          end
        end
      end
    end

    out_data_d = {back_d[sel_d], fast_d[sel_d], halt_d, pos_d[sel_d], sel_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NP; i++) begin
        el_q[i]   <= '0;
        fast_q[i] <= 1'b0;
        back_q[i] <= 1'b0;
        pos_q[i]  <= '0;
      end
      sel_q       <= '0;
      halt_q      <= 1'b0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      el_q   <= el_d;
      fast_q <= fast_d;
      back_q <= back_d;
      pos_q  <= pos_d;
      sel_q  <= sel_d;
      halt_q <= halt_d;
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_tick_q  <= s_axis_tdata[0];
      in_click_q <= s_axis_tdata[lfsc_pkg::CLICK_W:1];
    end
    if (move) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

// ===== hw/rtl/lfsc_checker.sv =====
`include "led_flash_sequence_controller_unit_macros.svh"

module lfsc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [lfsc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  // nothing pending while in reset
  `LFSC_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !m_axis_tvalid, "result pending in reset")

  // a stalled result item is held
  `LFSC_ASSERT(a_stall_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  // an accepted event yields a result when the receiver keeps up
  `LFSC_ASSERT(a_latency, (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready |=> m_axis_tvalid, "result late")

  // a fresh result always traces back to an accepted event
  `LFSC_ASSERT(a_no_invent, $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2), "result without event")

endmodule

bind led_flash_sequence_controller_unit lfsc_checker u_lfsc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
